/* sv/smr90_pkg.sv */
// Shared constants and helpers for the 90-degree matrix rotator.
package smr90_pkg;

	localparam int MAX_SIZE = 8;
	localparam int DATA_W   = 32;
	localparam int SIZE_W   = 4;                        // width of the size register
	localparam int IDX_W    = $clog2(MAX_SIZE);         // row / column index
	localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = 7;                        // load counter width

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

	// Clamp the raw register value to 1..MAX_SIZE.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
		logic [SIZE_W-1:0] n;
		n = raw;
		if (n == '0)
			n = SIZE_W'(1);
		if (n > SIZE_W'(MAX_SIZE))
			n = SIZE_W'(MAX_SIZE);
		return n;
	endfunction

endpackage

/* sv/square_matrix_rotate_90.sv */
// Square matrix rotator: loads N x N elements, emits them rotated 90 degrees clockwise.
// rot_valid rises after the accepting edge moves the state to emit and a read, held while
// an earlier item is still undrained, fills the read data and valid registers; load and
// emission each run at one item per cycle while elem_valid / rot_ready allow, and take turns.
// Reset clears the load counter and the state, and sets the size register to 8;
// the element store is not cleared, every entry is written before it is read.
module square_matrix_rotate_90 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [smr90_pkg::SIZE_W-1:0] cfg_wr_data,
	input  logic                         elem_valid,
	output logic                         elem_ready,
	input  logic signed [smr90_pkg::DATA_W-1:0] element_value,
	output logic                         rot_valid,
	input  logic                         rot_ready,
	output logic signed [smr90_pkg::DATA_W-1:0] rotated_value,
	output logic                         is_last
);
	import smr90_pkg::*;

	typedef enum logic {ST_LOAD, ST_EMIT} state_t;

	state_t                 state_q;
	logic [SIZE_W-1:0]      size_q;       // raw size register
	logic [CNT_W-1:0]       load_cnt_q;
	logic [SIZE_W-1:0]      emit_n_q;     // size latched for the emission pass
	logic [IDX_W-1:0]       r_q;          // output row
	logic [IDX_W-1:0]       c_q;          // output column
	logic                   out_valid_q;
	logic                   out_last_q;
	logic [DATA_W-1:0]      rd_data_q;

	// element store: one write port (load), one registered read port (emit)
	logic [DATA_W-1:0]      mem [DEPTH];

	logic [SIZE_W-1:0]      n_cur;
	logic [CNT_W-1:0]       total;
	logic [CNT_W-1:0]       slot;
	logic                   load_acc;
	logic                   load_done;
	logic                   rd_en;
	logic                   rd_last;
	logic [IDX_W-1:0]       src_row;      // N-1-c
	logic [ADDR_W-1:0]      rd_addr;

	// ---------------- load side ----------------
	// Size in effect right now; a size change mid-load that leaves the count at or past
	// the end of the new size ends the load early, the arriving item going to its last slot.
	assign n_cur     = eff_size(size_q);
	assign total     = CNT_W'(n_cur) * CNT_W'(n_cur);
	assign slot      = (load_cnt_q >= total - CNT_W'(1)) ? total - CNT_W'(1) : load_cnt_q;
	assign elem_ready = (state_q == ST_LOAD);
	assign load_acc  = elem_valid && elem_ready;
	assign load_done = (load_cnt_q + CNT_W'(1)) >= total;

	// ---------------- emit side ----------------
	// Rotation is an address map: out(r,c) = in(N-1-c, r). A read is issued only
	// when the output register is empty or being drained this cycle, so the read
	// data register doubles as the output register and no skid stage is needed.
	assign src_row = IDX_W'(emit_n_q - SIZE_W'(1) - SIZE_W'(c_q));
	assign rd_addr = ADDR_W'(src_row) * ADDR_W'(emit_n_q) + ADDR_W'(r_q);
	assign rd_en   = (state_q == ST_EMIT) && (!out_valid_q || rot_ready);
	assign rd_last = (SIZE_W'(r_q) == emit_n_q - SIZE_W'(1))
	              && (SIZE_W'(c_q) == emit_n_q - SIZE_W'(1));

	always_ff @(posedge clk) begin
		if (load_acc)
			mem[slot[ADDR_W-1:0]] <= element_value;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			size_q      <= SIZE_RESET;
			load_cnt_q  <= '0;
			emit_n_q    <= SIZE_RESET;
			r_q         <= '0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				size_q <= cfg_wr_data;

			// drained with nothing new behind it
			if (rot_valid && rot_ready && !rd_en)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_LOAD: begin
					if (load_acc) begin
						if (load_done) begin
							load_cnt_q <= '0;
							emit_n_q   <= n_cur;
							r_q        <= '0;
							c_q        <= '0;
							state_q    <= ST_EMIT;
						end else begin
							load_cnt_q <= load_cnt_q + CNT_W'(1);
						end
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						out_valid_q <= 1'b1;
						out_last_q  <= rd_last;
						if (rd_last) begin
							state_q <= ST_LOAD;
						end else if (SIZE_W'(c_q) == emit_n_q - SIZE_W'(1)) begin
							c_q <= '0;
							r_q <= r_q + IDX_W'(1);
						end else begin
							c_q <= c_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign rot_valid     = out_valid_q;
	assign rotated_value = rd_data_q;
	assign is_last       = out_last_q;

	// ---------------- checks ----------------
	a_cnt_clear_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> load_cnt_q == '0)
		else $error("load counter not cleared during emission");

	a_enter_emit: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc && load_done |=> state_q == ST_EMIT && r_q == '0 && c_q == '0)
		else $error("emission did not start at row 0, column 0");

	a_last_ends_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && rd_last |=> state_q == ST_LOAD && out_valid_q && out_last_q)
		else $error("last read did not end emission");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> SIZE_W'(r_q) < emit_n_q && SIZE_W'(c_q) < emit_n_q)
		else $error("emit index out of range");

	a_no_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !load_acc)
		else $error("item accepted during emission");

endmodule

/* tb/square_matrix_rotate_90_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the 90-degree clockwise square matrix rotator.

class rot90_tracker;
	typedef struct {
		logic signed [smr90_pkg::DATA_W-1:0] value;
		logic                                last;
	} rotated_t;

	logic [smr90_pkg::DATA_W-1:0] elems [smr90_pkg::DEPTH];
	logic [smr90_pkg::CNT_W-1:0]  load_cnt;
	logic [smr90_pkg::SIZE_W-1:0] size_reg;
	rotated_t                     expected_rotated [$];
	int                           errors;

	function new();
		load_cnt = '0;
		size_reg = smr90_pkg::SIZE_RESET;
		errors   = 0;
	endfunction

	function void write_size(input logic [smr90_pkg::SIZE_W-1:0] v);
		size_reg = v;
	endfunction

	// size in use: zero acts as 1, anything above the maximum as the maximum
	function int unsigned side();
		int unsigned n;
		n = size_reg;
		if (n == 0)
			n = 1;
		if (n > smr90_pkg::MAX_SIZE)
			n = smr90_pkg::MAX_SIZE;
		return n;
	endfunction

	function int pending();
		return expected_rotated.size();
	endfunction

	function void load_element(input logic signed [smr90_pkg::DATA_W-1:0] v);
		int unsigned n, total, slot, r, c;
		rotated_t    item;
		n     = side();
		total = n * n;
		slot  = load_cnt;
		// a load that already reached the end of a shrunk matrix lands on its last slot
		if (slot >= total - 1)
			slot = total - 1;
		elems[slot] = v;
		if (load_cnt + 1 < total) begin
			load_cnt = load_cnt + 1'b1;
			return;
		end
		for (r = 0; r < n; r++) begin
			for (c = 0; c < n; c++) begin
				item.value = elems[(n - 1 - c) * n + r];
				item.last  = (r == n - 1) && (c == n - 1);
				expected_rotated.push_back(item);
			end
		end
		load_cnt = '0;
	endfunction

	function void check_rotated(input logic signed [smr90_pkg::DATA_W-1:0] v, input logic last);
		rotated_t want;
		if (expected_rotated.size() == 0) begin
			errors++;
			$display("%0t: unexpected rotated item, value %0d is_last %0b", $time, v, last);
			return;
		end
		want = expected_rotated.pop_front();
		if (v !== want.value) begin
			errors++;
			$display("%0t: rotated_value mismatch, expected %0d actual %0d",
				$time, want.value, v);
		end
		if (last !== want.last) begin
			errors++;
			$display("%0t: is_last mismatch, expected %0b actual %0b", $time, want.last, last);
		end
	endfunction
endclass

module square_matrix_rotate_90_tb;
	import smr90_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 3;
	localparam int ITEM_TARGET  = 350;
	localparam int IDLE_PCT     = 17;
	// first rotated item shows once the state and read data registers have updated; leave margin
	localparam int HOLD_OFF     = 8;
	localparam int DRAIN_CYCLES = 2 * DEPTH;
	localparam int STALL_LIMIT  = 2000;

	localparam logic [DATA_W-1:0] ELEM_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] ELEM_MAX  = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] ELEM_ONES = 32'hffff_ffff;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     cfg_wr_en     = 1'b0;
	logic [SIZE_W-1:0]        cfg_wr_data   = '0;
	logic                     elem_valid    = 1'b0;
	logic signed [DATA_W-1:0] element_value = '0;
	logic                     rot_ready     = 1'b0;
	logic                     elem_ready;
	logic                     rot_valid;
	logic signed [DATA_W-1:0] rotated_value;
	logic                     is_last;

	int send_idle_pct = IDLE_PCT;   // read only by the sending process
	int stall_pct     = IDLE_PCT;   // updated with NBAs, read by the result side
	int items_sent    = 0;
	int quiet_cycles  = 0;

	rot90_tracker tracker = new();

	always #HALF_PERIOD clk = ~clk;

	square_matrix_rotate_90 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.elem_valid    (elem_valid),
		.elem_ready    (elem_ready),
		.element_value (element_value),
		.rot_valid     (rot_valid),
		.rot_ready     (rot_ready),
		.rotated_value (rotated_value),
		.is_last       (is_last)
	);

	// Result side: random backpressure, check every accepted item against the
	// oldest prediction, and bail out if the interface goes silent for too long.
	// All reads here see the values from before the edge.
	always @(posedge clk) begin
		rot_ready <= ($urandom_range(99) >= stall_pct);
		if (rot_valid && rot_ready)
			tracker.check_rotated(rotated_value, is_last);
		if ((elem_valid && elem_ready) || (rot_valid && rot_ready) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("square_matrix_rotate_90 regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one element, with a random gap in front of it. valid is only dropped
	// when a gap is taken, so back-to-back items keep it high across the edge.
	// The prediction is updated here, in the same process, so the sender can
	// rely on the load count as soon as the item is taken.
	task automatic send_element(input logic signed [DATA_W-1:0] v);
		int gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			elem_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_valid    <= 1'b1;
		element_value <= v;
		@(posedge clk iff elem_ready);
		tracker.load_element(v);
		items_sent++;
	endtask

	// Stop sending and let the block drain. A partial load produces nothing,
	// so after the last result there is a short hold-off before anything else.
	task automatic settle();
		elem_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	// Size register is only touched after the results have drained; a load may be in progress.
	task automatic write_size(input logic [SIZE_W-1:0] v);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		tracker.write_size(v);
		cfg_wr_en   <= 1'b0;
	endtask

	// Keep loading until the matrix in progress is complete.
	task automatic send_matrix();
		do
			send_element(pick_element());
		while (tracker.load_cnt != 0);
	endtask

	// Extremes show up often enough to land in every output position.
	function automatic logic [DATA_W-1:0] pick_element();
		case ($urandom_range(9))
			0:       return ELEM_MIN;
			1:       return ELEM_MAX;
			2:       return '0;
			3:       return ELEM_ONES;
			default: return $urandom;
		endcase
	endfunction

	// Mostly small matrices; larger ones and the out-of-range codes now and then.
	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned roll;
		int unsigned pick;
		roll = $urandom_range(99);
		if (roll < 8) begin
			pick = $urandom_range(7);
			return (pick == 0) ? SIZE_W'(0) : SIZE_W'(pick + MAX_SIZE);
		end
		if (roll < 28)
			return SIZE_W'($urandom_range(MAX_SIZE, 5));
		return SIZE_W'($urandom_range(4, 1));
	endfunction

	initial begin : stimulus
		bit          quiet;
		int unsigned partial;
		int unsigned n;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// Reset size is 8: five items must give no output at all. Then shrink to 2
		// mid-load; the load is already past the end, so the next item lands on the
		// last slot and finishes the 2x2.
		send_element(ELEM_MIN);
		send_element(ELEM_MAX);
		send_element('0);
		send_element(ELEM_ONES);
		send_element(32'sd1);
		write_size(SIZE_W'(2));
		send_element(32'h5555_5555);

		// plain 2x2 with distinct entries to pin down the rotation
		send_element(32'haaaa_aaaa);
		send_element(32'sd1);
		send_element(32'sd2);
		send_element(32'sd3);

		// 1x1 passes straight through; size code zero behaves the same
		write_size(SIZE_W'(1));
		send_element(ELEM_MIN);
		send_element(ELEM_MAX);
		write_size('0);
		send_element(ELEM_ONES);

		// Size code above the maximum acts as 8: four items stay silent. Shrinking
		// to 3 mid-load then continues the same load up to nine items.
		write_size(SIZE_W'(15));
		repeat (4) send_element(pick_element());
		write_size(SIZE_W'(3));
		send_matrix();

		// ---- random part ----
		while (items_sent < ITEM_TARGET) begin
			// one long stretch with no gaps and no backpressure
			quiet         = (items_sent >= 120) && (items_sent < 220);
			send_idle_pct = quiet ? 0 : IDLE_PCT;
			stall_pct    <= quiet ? 0 : IDLE_PCT;

			if ($urandom_range(99) < 70)
				write_size(pick_size());

			n = tracker.side();
			if (n > 1 && $urandom_range(99) < 15) begin
				// broken load: stop part way, change the size, finish under the new one
				partial = $urandom_range(n * n - 1, 1);
				repeat (partial) send_element(pick_element());
				write_size(pick_size());
				send_matrix();
			end

			repeat ($urandom_range(3, 1)) send_matrix();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("square_matrix_rotate_90 regression: pass");
		else
			$display("square_matrix_rotate_90 regression: fail");
		$finish;
	end
endmodule
